@@ rtl/ads_pkg.sv @@
package ads_pkg;

	localparam int STAMP_BITS = 32;
	localparam int DEN_BITS   = STAMP_BITS + 2;
	localparam int PROD_BITS  = 2 * STAMP_BITS;
	localparam int FIELD_BITS = 32;
	localparam int RES_BITS   = 32;

	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [DEN_BITS-1:0]   den_t;
	typedef logic [PROD_BITS-1:0]  prod_t;
	typedef logic [RES_BITS-1:0]   quot_t;

	localparam quot_t RES_MAX = {1'b0, {(RES_BITS-1){1'b1}}};
	localparam quot_t RES_MIN = {1'b1, {(RES_BITS-1){1'b0}}};

	typedef struct packed {
		logic [FIELD_BITS-1:0] poll_tx_time;
		logic [FIELD_BITS-1:0] poll_rx_time;
		logic [FIELD_BITS-1:0] resp_tx_time;
		logic [FIELD_BITS-1:0] resp_rx_time;
		logic [FIELD_BITS-1:0] final_tx_time;
		logic [FIELD_BITS-1:0] final_rx_time;
	} stamps_t;

	typedef struct packed {
		logic signed [RES_BITS-1:0] flight_time;
		logic                       result_valid;
	} tof_t;

	typedef struct packed {
		logic  vld;
		logic  ok;
		logic  neg;
		den_t  den;
		prod_t num;
		den_t  rem;
		quot_t quot;
		logic  ovf;
	} div_cell_t;

endpackage

@@ rtl/ads_if.sv @@
interface ads_in_if;
	import ads_pkg::*;
	logic    valid;
	logic    ready;
	stamps_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ads_out_if;
	import ads_pkg::*;
	logic valid;
	logic ready;
	tof_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/ads_front.sv @@
module ads_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  ads_pkg::stamps_t   in_data,
	output ads_pkg::div_cell_t head
);
	import ads_pkg::*;

	stamp_t    t0, t1, t2, t3, t4, t5;
	logic      vld_s1, vld_s2, vld_s3;
	logic      ok_s1, ok_s2;
	stamp_t    ra_s1, rb_s1, da_s1, db_s1;
	prod_t     p_s2, q_s2;
	den_t      den_s2;
	den_t      den_sum;
	logic [PROD_BITS:0] diff;
	div_cell_t nxt_head;
	div_cell_t head_s3;

	always_comb begin
		t0 = stamp_t'(in_data.poll_tx_time);
		t1 = stamp_t'(in_data.poll_rx_time);
		t2 = stamp_t'(in_data.resp_tx_time);
		t3 = stamp_t'(in_data.resp_rx_time);
		t4 = stamp_t'(in_data.final_tx_time);
		t5 = stamp_t'(in_data.final_rx_time);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= (t0 != '0) && (t1 != '0) && (t2 != '0) && (t3 != '0) &&
			         (t4 != '0) && (t5 != '0);
			ra_s1 <= t3 - t0;
			rb_s1 <= t5 - t2;
			da_s1 <= t4 - t3;
			db_s1 <= t2 - t1;
		end
	end

	assign den_sum = den_t'(ra_s1) + den_t'(rb_s1) + den_t'(da_s1) + den_t'(db_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= prod_t'(ra_s1) * prod_t'(rb_s1);
			q_s2   <= prod_t'(da_s1) * prod_t'(db_s1);
			den_s2 <= den_sum;
			ok_s2  <= ok_s1 && (den_sum != '0);
		end
	end

	assign diff = {1'b0, p_s2} - {1'b0, q_s2};

	always_comb begin
		nxt_head      = '0;
		nxt_head.ok   = ok_s2;
		nxt_head.neg  = diff[PROD_BITS];
		nxt_head.den  = den_s2;
		nxt_head.num  = diff[PROD_BITS] ? (q_s2 - p_s2) : diff[PROD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s3 <= nxt_head;
		end
	end

	always_comb begin
		head     = head_s3;
		head.vld = vld_s3;
	end

endmodule

@@ rtl/ads_div_cell.sv @@
module ads_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ads_pkg::div_cell_t up,
	output ads_pkg::div_cell_t down
);
	import ads_pkg::*;

	logic [DEN_BITS:0] shifted;
	logic              ge;
	logic [DEN_BITS:0] trial;
	div_cell_t         nxt;
	div_cell_t         pay_q;
	logic              vld_q;

	assign shifted = {up.rem, up.num[PROD_BITS-1]};
	assign ge      = shifted >= {1'b0, up.den};
	assign trial   = shifted - {1'b0, up.den};

	always_comb begin
		nxt      = up;
		nxt.rem  = ge ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
		nxt.num  = {up.num[PROD_BITS-2:0], 1'b0};
		nxt.quot = {up.quot[RES_BITS-2:0], ge};
		nxt.ovf  = up.ovf | up.quot[RES_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= up.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		down     = pay_q;
		down.vld = vld_q;
	end

endmodule

@@ rtl/ads_twr_time_of_flight.sv @@
// Path from the input transfer to out valid: the front stages, the division cells, then the output register.
// Throughput: one exchange per cycle while the skid entry is empty; two front stages, the
// product stage and one restoring-division cell per numerator bit each hold one exchange.
// A two-entry output buffer lets input transfers continue while a result waits.
// Reset clears all valid flags at once; no clearing pass is needed.
module ads_twr_time_of_flight (
	input  logic          clk,
	input  logic          arst_n,
	ads_in_if.sink        stamps,
	ads_out_if.source     tof
);
	import ads_pkg::*;

	logic      en;
	logic      in_vld;
	div_cell_t chain [PROD_BITS+1];
	div_cell_t last;
	tof_t      res;
	logic      push;
	logic      pop;
	tof_t      out_q;
	tof_t      skid_q;
	logic      out_v_q;
	logic      skid_v_q;

	assign en           = !skid_v_q;
	assign stamps.ready = en;
	assign in_vld       = stamps.valid && en;

	ads_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_vld),
		.in_data (stamps.data),
		.head    (chain[0])
	);

	for (genvar i = 0; i < PROD_BITS; i++) begin : g_cell
		ads_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up     (chain[i]),
			.down   (chain[i+1])
		);
	end

	assign last = chain[PROD_BITS];

	always_comb begin
		res = '0;
		if (last.ok) begin
			res.result_valid = 1'b1;
			if (last.neg) begin
				res.flight_time = (last.ovf || last.quot[RES_BITS-1]) ? RES_MIN : -last.quot;
			end else begin
				res.flight_time = (last.ovf || last.quot[RES_BITS-1]) ? RES_MAX : last.quot;
			end
		end
	end

	assign push = last.vld && en;
	assign pop  = out_v_q && tof.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || pop) begin
			out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign tof.valid = out_v_q;
	assign tof.data  = out_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tof.valid && !tof.data.result_valid) |-> (tof.data.flight_time == '0))
		else $error("invalid result carries a nonzero flight time");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(stamps.valid && stamps.ready) |=> u_front.vld_s1)
		else $error("accepted transfer did not enter the front stage");

	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && $past(skid_v_q)) |-> $stable(last.vld))
		else $error("division chain advanced while output buffer full");
`endif

endmodule

@@ tb/ads_twr_time_of_flight_tb.sv @@
module ads_twr_time_of_flight_tb;
	import ads_pkg::*;

	localparam int EXCHANGE_COUNT = 1300;
	localparam int HOLD_AFTER     = 400;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 2 * STAMP_BITS + 20;
	localparam int IDLE_LIMIT     = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ads_in_if  stamps();
	ads_out_if tof();

	ads_twr_time_of_flight dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stamps (stamps),
		.tof    (tof)
	);

	always #5 clk = ~clk;

	stamps_t exchange_q[$];
	tof_t    flight_q[$];
	int      fail_count  = 0;
	int      sent_count  = 0;
	int      send_gap    = 0;
	int      send_calm   = 0;
	int      recv_stall  = 0;
	int      recv_calm   = 0;
	int      hold_left   = 0;
	bit      hold_done   = 1'b0;
	int      idle_cycles = 0;

	function automatic tof_t predict_flight(stamps_t s);
		stamp_t   t[6];
		stamp_t   ra, rb, da, db;
		den_t     den;
		prod_t    p, q, mag, quo;
		logic     neg;
		tof_t     r;
		r = '0;
		t[0] = s.poll_tx_time[STAMP_BITS-1:0];
		t[1] = s.poll_rx_time[STAMP_BITS-1:0];
		t[2] = s.resp_tx_time[STAMP_BITS-1:0];
		t[3] = s.resp_rx_time[STAMP_BITS-1:0];
		t[4] = s.final_tx_time[STAMP_BITS-1:0];
		t[5] = s.final_rx_time[STAMP_BITS-1:0];
		foreach (t[i])
			if (t[i] == '0)
				return r;
		ra = t[3] - t[0];
		rb = t[5] - t[2];
		da = t[4] - t[3];
		db = t[2] - t[1];
		den = den_t'(ra) + den_t'(rb) + den_t'(da) + den_t'(db);
		if (den == '0)
			return r;
		p = prod_t'(ra) * prod_t'(rb);
		q = prod_t'(da) * prod_t'(db);
		neg = p < q;
		mag = neg ? q - p : p - q;
		quo = mag / prod_t'(den);
		if (neg)
			r.flight_time = (quo >= prod_t'(RES_MIN)) ? RES_MIN : quot_t'(-quo);
		else
			r.flight_time = (quo > prod_t'(RES_MAX)) ? RES_MAX : quot_t'(quo);
		r.result_valid = 1'b1;
		return r;
	endfunction

	function automatic stamps_t make_exchange(stamp_t poll_tx, stamp_t poll_rx, stamp_t ra,
			stamp_t db, stamp_t da, stamp_t rb);
		stamps_t s;
		s = '0;
		s.poll_tx_time  = poll_tx;
		s.resp_rx_time  = stamp_t'(poll_tx + ra);
		s.final_tx_time = stamp_t'(poll_tx + ra + da);
		s.poll_rx_time  = poll_rx;
		s.resp_tx_time  = stamp_t'(poll_rx + db);
		s.final_rx_time = stamp_t'(poll_rx + db + rb);
		return s;
	endfunction

	function automatic stamps_t clear_stamp(stamps_t s, int idx);
		s[(5 - idx) * FIELD_BITS +: FIELD_BITS] = '0;
		return s;
	endfunction

	function automatic stamps_t random_exchange();
		int      kind;
		stamp_t  tof2, ra, rb, da, db, v;
		stamps_t s;
		kind = $urandom_range(0, 99);
		tof2 = $urandom_range(0, 4000);
		db = $urandom >> $urandom_range(0, 28);
		da = $urandom >> $urandom_range(0, 28);
		ra = db + tof2 + stamp_t'($urandom_range(0, 15)) - stamp_t'(8);
		rb = da + tof2 + stamp_t'($urandom_range(0, 15)) - stamp_t'(8);
		s = make_exchange($urandom, $urandom, ra, db, da, rb);
		if (kind >= 55 && kind < 75) begin
			s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else if (kind >= 75 && kind < 85) begin
			s = make_exchange($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (kind >= 85 && kind < 95) begin
			s = clear_stamp(s, $urandom_range(0, 5));
			if ($urandom_range(0, 3) == 0)
				s = clear_stamp(s, $urandom_range(0, 5));
		end else if (kind >= 95) begin
			v = $urandom | 32'd1;
			s = {6{v}};
		end
		return s;
	endfunction

	function automatic int next_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(30, 200);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(15, 120);
	endfunction

	// sender: predict on each transfer, then present the next exchange
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamps.valid <= 1'b0;
			stamps.data  <= '0;
			send_gap     <= 0;
		end else begin
			if (stamps.valid && stamps.ready) begin
				flight_q.push_back(predict_flight(stamps.data));
				sent_count <= sent_count + 1;
			end
			if (!stamps.valid || stamps.ready) begin
				if (send_gap != 0 || exchange_q.size() == 0) begin
					stamps.valid <= 1'b0;
					if (send_gap != 0)
						send_gap <= send_gap - 1;
				end else begin
					stamps.valid <= 1'b1;
					stamps.data  <= exchange_q.pop_front();
					send_gap     <= next_idle(send_calm);
				end
			end
		end
	end

	// hold off the receiver once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_count >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// receiver: check each transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : receiver
		tof_t want;
		if (!arst_n) begin
			tof.ready  <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (tof.valid && tof.ready) begin
				if (flight_q.size() == 0) begin
					if (fail_count < 10)
						$display("mismatch: unexpected result flight_time=%0d result_valid=%0b",
							tof.data.flight_time, tof.data.result_valid);
					fail_count++;
				end else begin
					want = flight_q.pop_front();
					if (tof.data.flight_time !== want.flight_time ||
							tof.data.result_valid !== want.result_valid) begin
						if (fail_count < 10)
							$display("mismatch: flight_time exp %0d got %0d, result_valid exp %0b got %0b",
								want.flight_time, tof.data.flight_time,
								want.result_valid, tof.data.result_valid);
						fail_count++;
					end
				end
			end
			if (hold_left != 0) begin
				tof.ready <= 1'b0;
			end else if (recv_stall != 0) begin
				tof.ready  <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				tof.ready  <= 1'b1;
				recv_stall <= next_idle(recv_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((stamps.valid && stamps.ready) || (tof.valid && tof.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL ads_twr_time_of_flight");
				$finish;
			end
		end
	end

	initial begin
		stamps_t base;

		base = make_exchange(32'h0000_1000, 32'h8000_0000, 32'd2400, 32'd2000, 32'd1800,
			32'd2200);
		exchange_q.push_back(base);
		exchange_q.push_back('0);
		for (int i = 0; i < 6; i++)
			exchange_q.push_back(clear_stamp(base, i));
		exchange_q.push_back('1);
		exchange_q.push_back({6{32'd5}});
		exchange_q.push_back(make_exchange(32'h7FFF_FFF0, 32'h1, 32'd100, 32'd5000, 32'd6000,
			32'd100));
		// largest positive and negative flight times
		exchange_q.push_back(make_exchange(32'd2, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0,
			32'hFFFF_FFFF));
		exchange_q.push_back(make_exchange(32'd3, 32'd9, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0));
		exchange_q.push_back(make_exchange(32'hFFFF_FF00, 32'h100, 32'd777, 32'd333, 32'd777,
			32'd333));
		exchange_q.push_back(make_exchange(32'hFFFF_FFF0, 32'hFFFF_FF00, 32'h100, 32'h80,
			32'h90, 32'h110));
		exchange_q.push_back({3{32'hAAAA_AAAA, 32'h5555_5555}});
		exchange_q.push_back({3{32'h5555_5555, 32'hAAAA_AAAA}});
		exchange_q.push_back({3{32'hFFFF_FFFF, 32'h0000_0001}});
		exchange_q.push_back({3{32'h0000_0001, 32'hFFFF_FFFF}});
		exchange_q.push_back({6{32'h8000_0000}});
		for (int i = 0; i < EXCHANGE_COUNT; i++)
			exchange_q.push_back(random_exchange());

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (exchange_q.size() != 0 || stamps.valid)
			@(posedge clk);
		while (flight_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("PASS ads_twr_time_of_flight");
		else
			$display("FAIL ads_twr_time_of_flight");
		$finish;
	end

endmodule
